// ===== rtl/hsspd_pkg.sv =====
`timescale 1ns / 1ps

package hsspd_pkg;

  // shared divider: 33-bit dividend, one quotient bit per cycle
  localparam int DIV_W = 33;
  localparam int CNT_W = $clog2(DIV_W + 1);

  localparam logic [15:0] FULL_TURN   = 16'd46080;
  localparam logic [15:0] RAW_FULL    = 16'd65535;
  localparam logic [15:0] RAW_HALF    = 16'd32767;
  localparam logic [15:0] TURN_HALF   = 16'd23040;
  localparam logic [31:0] MIN_IVAL    = 32'd300;
  localparam logic [31:0] SLOW_IVAL   = 32'd1000000;
  localparam logic [31:0] SPEED_SCALE = 32'd5760;
  localparam logic [DIV_W-1:0] SPEED_NUM = 33'd5760000000;

  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_STEPS_PER_REV = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_SPEED     = 3'd1;
  localparam logic [IDX_W-1:0] REG_LIMITS_ON     = 3'd2;
  localparam logic [IDX_W-1:0] REG_MIN_ANGLE     = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_ANGLE     = 3'd4;
  localparam logic [IDX_W-1:0] REG_HOME_OFFSET   = 3'd5;

  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ANGLE,
    S_GOAL,
    S_SETGOAL,
    S_TICK,
    S_DIV,
    S_STEP,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    OP_ANGLE,
    OP_GOAL,
    OP_IVAL
  } op_t;

  // half-step coil sequence
  function automatic logic [3:0] coil_of(input logic [2:0] phase);
    logic [3:0] pat;
    unique case (phase)
      3'd0: pat = 4'h1;
      3'd1: pat = 4'h3;
      3'd2: pat = 4'h2;
      3'd3: pat = 4'h6;
      3'd4: pat = 4'h4;
      3'd5: pat = 4'hC;
      3'd6: pat = 4'h8;
      3'd7: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage

// ===== rtl/halfstep_stepper_position_driver.sv =====
`timescale 1ns / 1ps

// Half-step driver for one four-coil stepper, moving toward a commanded step.
// Input words: in_req_type 0 carries a position command (in_position_raw,
// 65535 = one turn), 1 carries a microsecond tick (in_now_us). Each input
// word yields exactly one output word: coil levels, a stepped flag, and the
// current and goal step positions after that word.
// Configuration writes (cfg_valid/cfg_ready, always ready) are to go in only
// while the block is idle; the block itself does not enforce this. Indexes beyond the register list are dropped.
// All division runs through one shared restoring divider, one quotient bit
// per cycle. A command takes two divisions, and the next item is accepted
// only once the block is back in idle after writing its output word. A tick
// that steps takes one division, or none when the speed is below one step
// per second; a tick that does not step takes no division.
// in_stall is high whenever an item is in flight. The output register holds
// one word; while it waits under out_stall the next item is still accepted
// and worked, and only its final write-back waits for the slot.
// Reset clears positions, phase, due time, output valid and the coil-drive
// flag, and loads the register defaults.
module halfstep_stepper_position_driver (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_req_type,
  input  logic [15:0]                       in_position_raw,
  input  logic [31:0]                       in_now_us,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [3:0]                        out_coil_pattern,
  output logic                              out_stepped,
  output logic signed [31:0]                out_position_now,
  output logic signed [31:0]                out_position_goal,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hsspd_pkg::IDX_W-1:0]       cfg_index,
  input  logic [31:0]                       cfg_data
);

  localparam int DW = hsspd_pkg::DIV_W;
  localparam int CW = hsspd_pkg::CNT_W;

  hsspd_pkg::state_t state_r, state_nxt;
  hsspd_pkg::op_t    op_r, op_nxt;

  logic [15:0] spr_r, spr_nxt;
  logic [15:0] speed_r, speed_nxt;
  logic        lim_r, lim_nxt;
  logic [15:0] amin_r, amin_nxt;
  logic [15:0] amax_r, amax_nxt;
  logic [31:0] home_r, home_nxt;

  logic [31:0] pos_r, pos_nxt;
  logic [31:0] goal_r, goal_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [31:0] due_r, due_nxt;
  logic        driven_r, driven_nxt;

  logic [15:0] raw_r, raw_nxt;
  logic [31:0] now_r, now_nxt;
  logic        stepped_r, stepped_nxt;

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  out_coil_r, out_coil_nxt;
  logic        out_stepped_r, out_stepped_nxt;
  logic [31:0] out_now_r, out_now_nxt;
  logic [31:0] out_goal_r, out_goal_nxt;

  logic [15:0]   mul_a, mul_b;
  logic [31:0]   mul_p;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;
  logic          ge;
  logic [15:0]   ang;
  logic [31:0]   lag;
  logic [31:0]   ival;

  assign in_stall          = (state_r != hsspd_pkg::S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_coil_pattern  = out_coil_r;
  assign out_stepped       = out_stepped_r;
  assign out_position_now  = out_now_r;
  assign out_position_goal = out_goal_r;

  // one shared 16x16 multiplier, operands chosen by state
  always_comb begin
    mul_a = speed_r;
    mul_b = spr_r;
    if (state_r == hsspd_pkg::S_ANGLE) begin
      mul_a = raw_r;
      mul_b = hsspd_pkg::FULL_TURN;
    end else if (state_r == hsspd_pkg::S_GOAL) begin
      mul_a = ang;
      mul_b = spr_r;
    end
  end
  assign mul_p = mul_a * mul_b;

  // clamp the angle quotient when limits are on
  always_comb begin
    ang = quo_r[15:0];
    if (lim_r) begin
      if (ang < amin_r) ang = amin_r;
      if (ang > amax_r) ang = amax_r;
    end
  end

  // restoring divide step
  assign rem_sh = {rem_r, quo_r[DW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign ge     = !diff[DW+1];

  assign lag  = now_r - due_r;
  assign ival = (quo_r < DW'(hsspd_pkg::MIN_IVAL)) ? hsspd_pkg::MIN_IVAL : quo_r[31:0];

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    spr_nxt         = spr_r;
    speed_nxt       = speed_r;
    lim_nxt         = lim_r;
    amin_nxt        = amin_r;
    amax_nxt        = amax_r;
    home_nxt        = home_r;
    pos_nxt         = pos_r;
    goal_nxt        = goal_r;
    phase_nxt       = phase_r;
    due_nxt         = due_r;
    driven_nxt      = driven_r;
    raw_nxt         = raw_r;
    now_nxt         = now_r;
    stepped_nxt     = stepped_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    den_nxt         = den_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_valid_r;
    out_coil_nxt    = out_coil_r;
    out_stepped_nxt = out_stepped_r;
    out_now_nxt     = out_now_r;
    out_goal_nxt    = out_goal_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        hsspd_pkg::REG_STEPS_PER_REV: spr_nxt   = cfg_data[15:0];
        hsspd_pkg::REG_MAX_SPEED:     speed_nxt = cfg_data[15:0];
        hsspd_pkg::REG_LIMITS_ON:     lim_nxt   = cfg_data[0];
        hsspd_pkg::REG_MIN_ANGLE:     amin_nxt  = cfg_data[15:0];
        hsspd_pkg::REG_MAX_ANGLE:     amax_nxt  = cfg_data[15:0];
        hsspd_pkg::REG_HOME_OFFSET:   home_nxt  = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      hsspd_pkg::S_IDLE: begin
        if (in_valid) begin
          raw_nxt     = in_position_raw;
          now_nxt     = in_now_us;
          stepped_nxt = 1'b0;
          state_nxt   = (in_req_type == hsspd_pkg::REQ_TICK) ? hsspd_pkg::S_TICK
                                                             : hsspd_pkg::S_ANGLE;
        end
      end
      hsspd_pkg::S_ANGLE: begin
        rem_nxt   = '0;
        quo_nxt   = {1'b0, mul_p} + DW'(hsspd_pkg::RAW_HALF);
        den_nxt   = DW'(hsspd_pkg::RAW_FULL);
        cnt_nxt   = CW'(DW);
        op_nxt    = hsspd_pkg::OP_ANGLE;
        state_nxt = hsspd_pkg::S_DIV;
      end
      hsspd_pkg::S_GOAL: begin
        rem_nxt   = '0;
        quo_nxt   = {1'b0, mul_p} + DW'(hsspd_pkg::TURN_HALF);
        den_nxt   = DW'(hsspd_pkg::FULL_TURN);
        cnt_nxt   = CW'(DW);
        op_nxt    = hsspd_pkg::OP_GOAL;
        state_nxt = hsspd_pkg::S_DIV;
      end
      hsspd_pkg::S_SETGOAL: begin
        goal_nxt  = quo_r[31:0] + home_r;
        state_nxt = hsspd_pkg::S_FIN;
      end
      hsspd_pkg::S_TICK: begin
        if ((pos_r != goal_r) && !lag[31]) begin
          if (mul_p < hsspd_pkg::SPEED_SCALE) begin
            quo_nxt   = DW'(hsspd_pkg::SLOW_IVAL);
            state_nxt = hsspd_pkg::S_STEP;
          end else begin
            rem_nxt   = '0;
            quo_nxt   = hsspd_pkg::SPEED_NUM;
            den_nxt   = {1'b0, mul_p};
            cnt_nxt   = CW'(DW);
            op_nxt    = hsspd_pkg::OP_IVAL;
            state_nxt = hsspd_pkg::S_DIV;
          end
        end else begin
          state_nxt = hsspd_pkg::S_FIN;
        end
      end
      hsspd_pkg::S_DIV: begin
        rem_nxt = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], ge};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          unique case (op_r)
            hsspd_pkg::OP_ANGLE: state_nxt = hsspd_pkg::S_GOAL;
            hsspd_pkg::OP_GOAL:  state_nxt = hsspd_pkg::S_SETGOAL;
            default:             state_nxt = hsspd_pkg::S_STEP;
          endcase
        end
      end
      hsspd_pkg::S_STEP: begin
        if ($signed(goal_r) > $signed(pos_r)) begin
          pos_nxt   = pos_r + 32'd1;
          phase_nxt = phase_r + 3'd1;
        end else begin
          pos_nxt   = pos_r - 32'd1;
          phase_nxt = phase_r - 3'd1;
        end
        driven_nxt  = 1'b1;
        due_nxt     = now_r + ival;
        stepped_nxt = 1'b1;
        state_nxt   = hsspd_pkg::S_FIN;
      end
      hsspd_pkg::S_FIN: begin
        // wait for the output slot
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_coil_nxt    = driven_r ? hsspd_pkg::coil_of(phase_r) : 4'h0;
          out_stepped_nxt = stepped_r;
          out_now_nxt     = pos_r;
          out_goal_nxt    = goal_r;
          state_nxt       = hsspd_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsspd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spr_r       <= 16'd4096;
      speed_r     <= 16'd240;
      lim_r       <= 1'b0;
      amin_r      <= 16'd0;
      amax_r      <= hsspd_pkg::FULL_TURN;
      home_r      <= 32'd0;
      pos_r       <= 32'd0;
      goal_r      <= 32'd0;
      phase_r     <= 3'd0;
      due_r       <= 32'd0;
      driven_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      spr_r       <= spr_nxt;
      speed_r     <= speed_nxt;
      lim_r       <= lim_nxt;
      amin_r      <= amin_nxt;
      amax_r      <= amax_nxt;
      home_r      <= home_nxt;
      pos_r       <= pos_nxt;
      goal_r      <= goal_nxt;
      phase_r     <= phase_nxt;
      due_r       <= due_nxt;
      driven_r    <= driven_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r          <= op_nxt;
    raw_r         <= raw_nxt;
    now_r         <= now_nxt;
    stepped_r     <= stepped_nxt;
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    den_r         <= den_nxt;
    cnt_r         <= cnt_nxt;
    out_coil_r    <= out_coil_nxt;
    out_stepped_r <= out_stepped_nxt;
    out_now_r     <= out_now_nxt;
    out_goal_r    <= out_goal_nxt;
  end

  // phase and position move together from reset
  a_phase_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == pos_r[2:0])
    else $error("coil phase out of step with position");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hsspd_pkg::S_STEP) |=>
      ((pos_r == $past(pos_r) + 32'd1) || (pos_r == $past(pos_r) - 32'd1)))
    else $error("step moved position by other than one");

  a_min_interval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hsspd_pkg::S_STEP) |=>
      ((due_r - now_r) >= hsspd_pkg::MIN_IVAL) && ((due_r - now_r) <= hsspd_pkg::SLOW_IVAL))
    else $error("step interval out of range");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hsspd_pkg::S_DIV) |-> (cnt_r != CW'(0)))
    else $error("divider running with zero count");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic REQ_CMD = 1'b0;
  localparam logic [hsspd_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [hsspd_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam longint unsigned TURN_UNITS   = 46080;
  localparam longint unsigned RAW_SPAN     = 65535;
  localparam longint unsigned RATE_UNIT    = 5760;
  localparam longint unsigned RATE_NUM     = 64'd5760000000;
  localparam longint unsigned SLOW_STEP_US = 1000000;
  localparam longint unsigned STEP_FLOOR_US = 300;
  // half-step coil sequence, phase 0 in the low nibble
  localparam logic [31:0] COIL_SEQ = 32'h98C46231;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES = 8;
  localparam int WORDS_PER_PHASE = 125;

  typedef struct packed {
    logic [3:0]         coil;
    logic               stepped;
    logic signed [31:0] pos_now;
    logic signed [31:0] pos_goal;
  } drive_word_t;

  typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

  typedef struct {
    row_kind_t                   kind;
    logic [hsspd_pkg::IDX_W-1:0] idx;
    logic [31:0]                 data;
    logic                        req;
    logic [15:0]                 raw;
    logic [31:0]                 now;
    bit                          typed;
    drive_word_t                 want;
  } stim_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_req_type;
  logic [15:0]       in_position_raw;
  logic [31:0]       in_now_us;
  logic              out_valid;
  logic              out_stall;
  logic [3:0]        out_coil_pattern;
  logic              out_stepped;
  logic signed [31:0] out_position_now;
  logic signed [31:0] out_position_goal;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [hsspd_pkg::IDX_W-1:0] cfg_index;
  logic [31:0]       cfg_data;

  halfstep_stepper_position_driver u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_position_raw   (in_position_raw),
    .in_now_us         (in_now_us),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_coil_pattern  (out_coil_pattern),
    .out_stepped       (out_stepped),
    .out_position_now  (out_position_now),
    .out_position_goal (out_position_goal),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // predicted register file
  logic [15:0] reg_spr;
  logic [15:0] reg_speed;
  logic        reg_limit_en;
  logic [15:0] reg_min_ang;
  logic [15:0] reg_max_ang;
  logic [31:0] reg_home;

  // predicted motor state
  logic [31:0] cur_step;
  logic [31:0] goal_step;
  logic [2:0]  phase_q;
  logic [31:0] due_us;
  logic        coils_on;

  drive_word_t pending_words [$];
  stim_row_t   directed_rows [$];
  drive_word_t seen_want;

  int mismatches;
  int quiet_cycles;
  int send_pct;
  int stall_pct;
  int hold_left;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic drive_word_t mk_word(input logic [3:0] coil, input logic st,
                                          input logic [31:0] pos, input logic [31:0] goal);
    drive_word_t w;
    w.coil = coil;
    w.stepped = st;
    w.pos_now = pos;
    w.pos_goal = goal;
    return w;
  endfunction

  // advance the predicted motor by one word and return what the block should emit
  function automatic drive_word_t drive_after(input logic req, input logic [15:0] raw,
                                              input logic [31:0] now);
    longint unsigned angle;
    longint unsigned steps;
    longint unsigned span;
    longint unsigned ival;
    logic [31:0]     lag;
    logic            moved;
    drive_word_t     w;
    moved = 1'b0;
    if (req != hsspd_pkg::REQ_TICK) begin
      angle = 64'(raw);
      angle = (angle * TURN_UNITS + RAW_SPAN / 2) / RAW_SPAN;
      if (reg_limit_en) begin
        if (angle < reg_min_ang) angle = 64'(reg_min_ang);
        if (angle > reg_max_ang) angle = 64'(reg_max_ang);
      end
      steps = (angle * reg_spr + TURN_UNITS / 2) / TURN_UNITS;
      goal_step = steps[31:0] + reg_home;
    end else begin
      lag = now - due_us;
      if (cur_step != goal_step && !lag[31]) begin
        span = 64'(reg_spr);
        span = span * reg_speed;
        if (span < RATE_UNIT) ival = SLOW_STEP_US;
        else ival = RATE_NUM / span;
        if (ival < STEP_FLOOR_US) ival = STEP_FLOOR_US;
        if ($signed(goal_step) > $signed(cur_step)) begin
          cur_step = cur_step + 32'd1;
          phase_q = phase_q + 3'd1;
        end else begin
          cur_step = cur_step - 32'd1;
          phase_q = phase_q - 3'd1;
        end
        coils_on = 1'b1;
        due_us = now + ival[31:0];
        moved = 1'b1;
      end
    end
    w.coil = coils_on ? COIL_SEQ[phase_q * 4 +: 4] : 4'h0;
    w.stepped = moved;
    w.pos_now = cur_step;
    w.pos_goal = goal_step;
    return w;
  endfunction

  function automatic void add_item(input logic req, input logic [15:0] raw,
                                   input logic [31:0] now);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.idx = '0;
    r.data = '0;
    r.req = req;
    r.raw = raw;
    r.now = now;
    r.typed = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_item_exp(input logic req, input logic [15:0] raw,
                                       input logic [31:0] now, input drive_word_t want);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.idx = '0;
    r.data = '0;
    r.req = req;
    r.raw = raw;
    r.now = now;
    r.typed = 1'b1;
    r.want = want;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_reg(input logic [hsspd_pkg::IDX_W-1:0] idx,
                                  input logic [31:0] data);
    stim_row_t r;
    r.kind = ROW_REG;
    r.idx = idx;
    r.data = data;
    r.req = REQ_CMD;
    r.raw = '0;
    r.now = '0;
    r.typed = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // offer one word, hold it until taken, then queue its expected word
  task automatic send_item(input logic req, input logic [15:0] raw, input logic [31:0] now,
                           input bit typed, input drive_word_t want);
    drive_word_t w;
    cfg_valid <= 1'b0;
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_position_raw <= raw;
    in_now_us <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    w = drive_after(req, raw, now);
    pending_words.push_back(typed ? want : w);
    @(negedge clk);
  endtask

  // drain first: registers change only while the block is idle
  task automatic write_reg(input logic [hsspd_pkg::IDX_W-1:0] idx, input logic [31:0] data);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      hsspd_pkg::REG_STEPS_PER_REV: reg_spr = data[15:0];
      hsspd_pkg::REG_MAX_SPEED:     reg_speed = data[15:0];
      hsspd_pkg::REG_LIMITS_ON:     reg_limit_en = data[0];
      hsspd_pkg::REG_MIN_ANGLE:     reg_min_ang = data[15:0];
      hsspd_pkg::REG_MAX_ANGLE:     reg_max_ang = data[15:0];
      hsspd_pkg::REG_HOME_OFFSET:   reg_home = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // receiver: random stalls, or a counted hold-off when asked
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          note_mismatch("word with nothing pending", {28'd0, out_coil_pattern}, 32'd0);
        end else begin
          seen_want = pending_words.pop_front();
          if (out_coil_pattern !== seen_want.coil)
            note_mismatch("coil_pattern", {28'd0, out_coil_pattern}, {28'd0, seen_want.coil});
          if (out_stepped !== seen_want.stepped)
            note_mismatch("stepped", {31'd0, out_stepped}, {31'd0, seen_want.stepped});
          if (out_position_now !== seen_want.pos_now)
            note_mismatch("position_now", out_position_now, seen_want.pos_now);
          if (out_position_goal !== seen_want.pos_goal)
            note_mismatch("position_goal", out_position_goal, seen_want.pos_goal);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("testbench NOT OK");
          $finish;
        end
      end
    end
  end

  initial begin
    logic        req;
    logic [15:0] raw;
    logic [31:0] now;
    logic [31:0] junk;
    logic [15:0] spr_v;
    logic [15:0] spd_v;
    logic [15:0] min_v;
    logic [15:0] max_v;
    logic        lim_v;
    logic [31:0] home_v;
    int          pick;
    stim_row_t   row;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_CMD;
    in_position_raw = '0;
    in_now_us = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    send_pct = 0;
    stall_pct = 0;
    hold_left = 0;

    reg_spr = 16'd4096;
    reg_speed = 16'd240;
    reg_limit_en = 1'b0;
    reg_min_ang = 16'd0;
    reg_max_ang = 16'd46080;
    reg_home = 32'd0;
    cur_step = '0;
    goal_step = '0;
    phase_q = '0;
    due_us = '0;
    coils_on = 1'b0;

    // reset defaults: 4096 half steps per turn, 5859 us between steps
    add_item_exp(hsspd_pkg::REQ_TICK, 16'h0000, 32'd0, mk_word(4'h0, 1'b0, 32'd0, 32'd0));
    add_item_exp(REQ_CMD, 16'h0000, 32'd0, mk_word(4'h0, 1'b0, 32'd0, 32'd0));
    add_item_exp(REQ_CMD, 16'hFFFF, 32'd0, mk_word(4'h0, 1'b0, 32'd0, 32'd4096));
    add_item_exp(hsspd_pkg::REQ_TICK, 16'h0000, 32'd0, mk_word(4'h3, 1'b1, 32'd1, 32'd4096));
    add_item_exp(hsspd_pkg::REQ_TICK, 16'h0000, 32'd5858,
                 mk_word(4'h3, 1'b0, 32'd1, 32'd4096));
    add_item_exp(hsspd_pkg::REQ_TICK, 16'h0000, 32'd5859,
                 mk_word(4'h2, 1'b1, 32'd2, 32'd4096));
    // timestamp ignored on a command, position ignored on a tick
    add_item_exp(REQ_CMD, 16'h0000, 32'hFFFFFFFF, mk_word(4'h2, 1'b0, 32'd2, 32'd0));
    add_item_exp(hsspd_pkg::REQ_TICK, 16'hFFFF, 32'hFFFFFFFF,
                 mk_word(4'h2, 1'b0, 32'd2, 32'd0));
    add_item_exp(hsspd_pkg::REQ_TICK, 16'h0000, 32'd11718,
                 mk_word(4'h3, 1'b1, 32'd1, 32'd0));
    // just inside the half-range of the wrapping compare
    add_item(hsspd_pkg::REQ_TICK, 16'h0000, 32'd2147501224);
    add_item(hsspd_pkg::REQ_TICK, 16'h0000, 32'd0);
    // home offset pushes the goal past the signed wrap
    add_reg(hsspd_pkg::REG_HOME_OFFSET, 32'h7FFFFFFF);
    add_item(REQ_CMD, 16'hFFFF, 32'd0);
    add_item(hsspd_pkg::REQ_TICK, 16'h0000, 32'd2147507083);
    // crossed limits
    add_reg(hsspd_pkg::REG_LIMITS_ON, 32'd1);
    add_reg(hsspd_pkg::REG_MIN_ANGLE, 32'd20000);
    add_reg(hsspd_pkg::REG_MAX_ANGLE, 32'd10000);
    add_reg(hsspd_pkg::REG_HOME_OFFSET, 32'd0);
    add_item(REQ_CMD, 16'h0000, 32'd0);
    // limits beyond a full turn
    add_reg(hsspd_pkg::REG_MIN_ANGLE, 32'd50000);
    add_reg(hsspd_pkg::REG_MAX_ANGLE, 32'd60000);
    add_item(REQ_CMD, 16'hFFFF, 32'd0);
    // zero steps per turn: goal is the offset, slowest interval
    add_reg(hsspd_pkg::REG_STEPS_PER_REV, 32'd0);
    add_item(REQ_CMD, 16'h8000, 32'd0);
    add_item(hsspd_pkg::REQ_TICK, 16'h0000, 32'hC0000000);
    // fastest setting hits the interval floor
    add_reg(hsspd_pkg::REG_STEPS_PER_REV, 32'hFFFF);
    add_reg(hsspd_pkg::REG_MAX_SPEED, 32'hFFFF);
    add_reg(hsspd_pkg::REG_LIMITS_ON, 32'd0);
    add_item(REQ_CMD, 16'h1234, 32'd0);
    add_item(hsspd_pkg::REQ_TICK, 16'h0000, 32'hC00F4240);
    add_item(hsspd_pkg::REQ_TICK, 16'h0000, 32'hC00F436C);
    add_reg(hsspd_pkg::REG_MAX_SPEED, 32'd0);
    add_item(hsspd_pkg::REQ_TICK, 16'h0000, 32'hC00F4498);
    // writes to unused indexes drop
    add_reg(REG_SPARE_LO, 32'hFFFFFFFF);
    add_reg(REG_SPARE_HI, 32'hFFFFFFFF);
    add_item(hsspd_pkg::REQ_TICK, 16'h0000, 32'hC01E86D8);

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) write_reg(row.idx, row.data);
      else send_item(row.req, row.raw, row.now, row.typed, row.want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 59; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 59; end
        default: begin send_pct = 33; stall_pct = 33; end
      endcase

      if (ph == 0) begin
        junk = '0;
        spr_v = 16'd1; spd_v = 16'd0; lim_v = 1'b0;
        min_v = 16'd0; max_v = 16'd0; home_v = 32'h80000000;
      end else if (ph == 1) begin
        junk = '1;
        spr_v = 16'hFFFF; spd_v = 16'hFFFF; lim_v = 1'b1;
        min_v = 16'hFFFF; max_v = 16'hFFFF; home_v = 32'h7FFFFFFF;
      end else begin
        junk = $urandom;
        // small step counts keep goals within reach of the tick stream
        spr_v = ($urandom_range(99) < 70) ? 16'($urandom_range(48, 1))
                                          : 16'($urandom_range(65535, 1));
        spd_v = ($urandom_range(2) == 0) ? 16'($urandom_range(16))
                                         : 16'($urandom_range(65535));
        lim_v = 1'($urandom_range(1));
        min_v = 16'($urandom_range(46080));
        max_v = 16'($urandom_range(46080));
        pick = $urandom_range(99);
        if (pick < 60) begin
          home_v = $urandom_range(40);
          home_v = home_v - 32'd20;
        end else if (pick < 80) begin
          home_v = 32'd0;
        end else begin
          home_v = $urandom;
        end
      end
      write_reg(hsspd_pkg::REG_STEPS_PER_REV, {junk[31:16], spr_v});
      write_reg(hsspd_pkg::REG_MAX_SPEED, {junk[15:0], spd_v});
      write_reg(hsspd_pkg::REG_LIMITS_ON, {junk[31:1], lim_v});
      write_reg(hsspd_pkg::REG_MIN_ANGLE, {junk[23:8], min_v});
      write_reg(hsspd_pkg::REG_MAX_ANGLE, {junk[27:12], max_v});
      write_reg(hsspd_pkg::REG_HOME_OFFSET, home_v);

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // long hold-off on the receiver while words keep coming
        if (ph == 4 && n == 10) hold_left = 400;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 20) begin
          req = REQ_CMD;
          now = $urandom;
          if (pick < 15) raw = 16'h0000;
          else if (pick < 30) raw = 16'hFFFF;
          else raw = 16'($urandom);
        end else begin
          req = hsspd_pkg::REQ_TICK;
          raw = 16'($urandom);
          if (pick < 55) now = due_us + $urandom_range(3);
          else if (pick < 70) now = due_us - 32'd1 - $urandom_range(3);
          else if (pick < 85) now = due_us + $urandom_range(2000000);
          else now = $urandom;
        end
        send_item(req, raw, now, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
